[rtl/davpf_pkg.sv]
`default_nettype none

package davpf_pkg;

  // Bytes of the header left after the version/length word
  localparam int HEADER_SKIP = 16;

  localparam int POS_W   = 24;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 2;
  localparam int REG_IDX_W = 1;

  localparam logic [POS_W-1:0] HDR_SKIP_LEN = POS_W'(HEADER_SKIP);
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] HLEN_PLAIN   = POS_W'(8);
  localparam logic [POS_W-1:0] HLEN_VENDOR  = POS_W'(12);
  localparam int VENDOR_BIT_POS = 7;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HDR,
    PH_CODE,
    PH_FLAGS,
    PH_LEN,
    PH_VENDOR,
    PH_VALUE,
    PH_DONE,
    PH_HALT
  } phase_t;

  localparam phase_t PH_START = (HEADER_SKIP == 0) ? PH_CODE : PH_HDR;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_CODE,
    REG_TARGET_VENDOR
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] target_code;
    logic [WORD_W-1:0] target_vendor;
  } cfg_t;

  // One byte handed from the input register to the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] value_offset;
    logic [POS_W-1:0] value_length;
    logic             malformed;
  } res_t;

endpackage

`default_nettype wire

[rtl/davpf_intf.sv]
`default_nettype none

interface davpf_in_if;
  import davpf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface davpf_out_if;
  import davpf_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] value_offset;
  logic [POS_W-1:0] value_length;
  logic             malformed;
  modport source (output valid, found, value_offset, value_length, malformed, input ready);
  modport sink (input valid, found, value_offset, value_length, malformed, output ready);
endinterface

interface davpf_cfg_if;
  import davpf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/davpf_cfg_regs.sv]
`default_nettype none

module davpf_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  davpf_cfg_if.sink          cfg_ch,
  output davpf_pkg::cfg_t    cfg_o
);
  import davpf_pkg::*;

  logic [WORD_W-1:0] code_r;
  logic [WORD_W-1:0] vendor_r;

  // Always take a write beat
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '0;
      vendor_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_TARGET_CODE:   code_r   <= cfg_ch.data;
        REG_TARGET_VENDOR: vendor_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_o.target_code   = code_r;
  assign cfg_o.target_vendor = vendor_r;

endmodule

`default_nettype wire

[rtl/davpf_parser.sv]
`default_nettype none

module davpf_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  davpf_pkg::beat_t   beat_i,
  input  davpf_pkg::cfg_t    cfg_i,
  output logic               res_valid_o,
  output davpf_pkg::res_t    res_o
);
  import davpf_pkg::*;

  phase_t             phase_r, phase_step, phase_nxt, hd_phase;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [WORD_W-1:0]  shift_r, shift_step, shift_nxt;
  logic [CNT_W-1:0]   fcnt_r, fcnt_step, fcnt_nxt;
  logic [WORD_W-1:0]  code_r, code_step, code_nxt;
  logic               vflag_r, vflag_step, vflag_nxt;
  logic [POS_W-1:0]   skip_r, skip_step, skip_nxt;
  logic               found_r, found_step, found_nxt;
  logic [POS_W-1:0]   off_r, off_step, off_nxt;
  logic [POS_W-1:0]   len_r, len_step, len_nxt;
  logic               mal_r, mal_step, mal_nxt;

  logic [WORD_W-1:0]  shift_in;
  logic [POS_W-1:0]   alen, hlen, skip_dec;
  logic               len_short, len_end, ven_end, hd_go, hd_match, found_mid;
  logic [POS_W-1:0]   hd_vlen, hd_total, off_sat;
  logic [WORD_W-1:0]  hd_vid;
  logic [CNT_W-1:0]   hd_pad;
  logic               bad;

  // Shared field decode
  assign shift_in  = {shift_r[WORD_W-BYTE_W-1:0], beat_i.data};
  assign alen      = shift_in[POS_W-1:0];
  assign hlen      = vflag_r ? HLEN_VENDOR : HLEN_PLAIN;
  assign len_short = alen < hlen;
  assign skip_dec  = skip_r - POS_W'(1);
  assign len_end   = (phase_r == PH_LEN) && (fcnt_r == CNT_W'(2));
  assign ven_end   = (phase_r == PH_VENDOR) && (fcnt_r == CNT_W'(3));
  assign hd_go     = (len_end && !len_short && !vflag_r) || ven_end;

  // AVP header complete: value length, padding and target match
  assign hd_vlen   = (phase_r == PH_LEN) ? (alen - hlen) : skip_r;
  assign hd_vid    = (phase_r == PH_LEN) ? '0 : shift_in;
  assign hd_match  = !found_r && (code_r == cfg_i.target_code) &&
                     (hd_vid == cfg_i.target_vendor);
  assign hd_pad    = CNT_W'(2'd0 - hd_vlen[CNT_W-1:0]);
  assign hd_total  = hd_vlen + {{(POS_W-CNT_W){1'b0}}, hd_pad};
  assign found_mid = found_r || (hd_go && hd_match);
  assign hd_phase  = (hd_total == '0) ? (found_mid ? PH_DONE : PH_CODE) : PH_VALUE;
  assign off_sat   = (pos_r == POS_MAX) ? POS_MAX : pos_r + POS_W'(1);

  // Next phase after one byte
  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      PH_HDR:    if (skip_dec == '0) phase_step = PH_CODE;
      PH_CODE:   if (fcnt_r == CNT_W'(3)) phase_step = PH_FLAGS;
      PH_FLAGS:  phase_step = PH_LEN;
      PH_LEN: begin
        if (len_end) begin
          if (len_short)    phase_step = PH_HALT;
          else if (vflag_r) phase_step = PH_VENDOR;
          else              phase_step = hd_phase;
        end
      end
      PH_VENDOR: if (ven_end) phase_step = hd_phase;
      PH_VALUE:  if (skip_dec == '0) phase_step = found_r ? PH_DONE : PH_CODE;
      default:   phase_step = phase_r;
    endcase
  end

  // Field shifter, counters and match record after one byte
  always_comb begin
    shift_step = shift_r;
    fcnt_step  = fcnt_r;
    code_step  = code_r;
    vflag_step = vflag_r;
    skip_step  = skip_r;
    found_step = found_r;
    off_step   = off_r;
    len_step   = len_r;
    mal_step   = mal_r;
    case (phase_r)
      PH_HDR: begin
        skip_step = skip_dec;
        if (skip_dec == '0) begin
          shift_step = '0;
          fcnt_step  = '0;
        end
      end
      PH_CODE: begin
        shift_step = shift_in;
        if (fcnt_r == CNT_W'(3)) begin
          code_step  = shift_in;
          shift_step = '0;
          fcnt_step  = '0;
        end else begin
          fcnt_step = fcnt_r + CNT_W'(1);
        end
      end
      PH_FLAGS: begin
        vflag_step = beat_i.data[VENDOR_BIT_POS];
        shift_step = '0;
        fcnt_step  = '0;
      end
      PH_LEN: begin
        shift_step = shift_in;
        if (len_end) begin
          shift_step = '0;
          fcnt_step  = '0;
          if (len_short) mal_step = 1'b1;
          else           skip_step = hd_vlen;
        end else begin
          fcnt_step = fcnt_r + CNT_W'(1);
        end
      end
      PH_VENDOR: begin
        shift_step = shift_in;
        if (!ven_end) fcnt_step = fcnt_r + CNT_W'(1);
      end
      PH_VALUE: begin
        skip_step = skip_dec;
        if (skip_dec == '0) begin
          shift_step = '0;
          fcnt_step  = '0;
        end
      end
      default: ;
    endcase
    // Enter the value: record a match, load the skip count
    if (hd_go) begin
      shift_step = '0;
      skip_step  = hd_total;
      fcnt_step  = (hd_total == '0) ? '0 : hd_pad;
      if (hd_match) begin
        found_step = 1'b1;
        off_step   = off_sat;
        len_step   = hd_vlen;
      end
    end
  end

  // Result of a message on its last byte
  always_comb begin
    bad = mal_step;
    case (phase_step)
      PH_HDR, PH_FLAGS, PH_LEN, PH_VENDOR: bad = 1'b1;
      PH_CODE:  if (fcnt_step != '0) bad = 1'b1;
      PH_VALUE: if (skip_step > {{(POS_W-CNT_W){1'b0}}, fcnt_step}) bad = 1'b1;
      default: ;
    endcase
    res_valid_o        = beat_i.valid && beat_i.last;
    res_o.found        = found_step;
    res_o.value_offset = found_step ? off_step : '0;
    res_o.value_length = found_step ? len_step : '0;
    res_o.malformed    = bad;
  end

  // Advance on a beat; restart after the last one
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    fcnt_nxt  = fcnt_r;
    code_nxt  = code_r;
    vflag_nxt = vflag_r;
    skip_nxt  = skip_r;
    found_nxt = found_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    mal_nxt   = mal_r;
    if (beat_i.valid) begin
      if (beat_i.last) begin
        phase_nxt = PH_START;
        pos_nxt   = '0;
        shift_nxt = '0;
        fcnt_nxt  = '0;
        code_nxt  = '0;
        vflag_nxt = 1'b0;
        skip_nxt  = HDR_SKIP_LEN;
        found_nxt = 1'b0;
        off_nxt   = '0;
        len_nxt   = '0;
        mal_nxt   = 1'b0;
      end else begin
        phase_nxt = phase_step;
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
        shift_nxt = shift_step;
        fcnt_nxt  = fcnt_step;
        code_nxt  = code_step;
        vflag_nxt = vflag_step;
        skip_nxt  = skip_step;
        found_nxt = found_step;
        off_nxt   = off_step;
        len_nxt   = len_step;
        mal_nxt   = mal_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= '0;
      shift_r <= '0;
      fcnt_r  <= '0;
      code_r  <= '0;
      vflag_r <= 1'b0;
      skip_r  <= HDR_SKIP_LEN;
      found_r <= 1'b0;
      off_r   <= '0;
      len_r   <= '0;
      mal_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      fcnt_r  <= fcnt_nxt;
      code_r  <= code_nxt;
      vflag_r <= vflag_nxt;
      skip_r  <= skip_nxt;
      found_r <= found_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      mal_r   <= mal_nxt;
    end
  end

  // A last beat always restarts the parse
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    beat_i.valid && beat_i.last |=> phase_r == PH_START && pos_r == '0 && !found_r)
    else $error("parser did not restart after last beat");

  // A match is never followed by a length error
  a_found_no_halt: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> phase_r != PH_HALT)
    else $error("halted after a match");

  // A length error always stops the parse
  a_mal_halts: assert property (@(posedge clk) disable iff (!rst_n)
    mal_r |-> phase_r == PH_HALT)
    else $error("malformed record without halt");

endmodule

`default_nettype wire

[rtl/davpf_out_reg.sv]
`default_nettype none

module davpf_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load_i,
  input  davpf_pkg::res_t    res_i,
  output logic               free_o,
  davpf_out_if.source        out_ch
);
  import davpf_pkg::*;

  logic valid_r;
  res_t res_r;

  assign free_o = !valid_r || out_ch.ready;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) res_r <= res_i;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.found        = res_r.found;
  assign out_ch.value_offset = res_r.value_offset;
  assign out_ch.value_length = res_r.value_length;
  assign out_ch.malformed    = res_r.malformed;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> free_o)
    else $error("result register overwritten");

endmodule

`default_nettype wire

[rtl/diameter_avp_finder.sv]
// Diameter AVP finder.
// in_ch takes one byte of a Diameter message body per beat, starting right
// after the 4-byte version/length word; last_byte marks the final byte.
// cfg_ch writes target_code (index 0) and target_vendor (index 1); it is
// always ready and is to be written only while no message is in flight.
// out_ch gives one beat per message: found, value_offset, value_length and
// malformed for the first AVP whose code and vendor id match the targets.
// Throughput: one byte per cycle. Every byte goes through an input register
// and one parse step; the result register is loaded by the step of the last
// byte, so out_ch.valid rises in the cycle after the parser consumes it.
// When out_ch stalls, body bytes keep flowing; only a last byte waits in
// the input register until the result register is free, and in_ch.ready
// then drops.
// Reset (rst_n low at a clock edge) clears both targets to 0, drops any
// pending byte and result, and restarts the parse at the header.
`default_nettype none

module diameter_avp_finder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  davpf_in_if.sink    in_ch,
  davpf_out_if.source out_ch,
  davpf_cfg_if.sink   cfg_ch
);
  import davpf_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_last_r;
  logic              out_free, consume, res_valid;
  beat_t             beat;
  cfg_t              cfg;
  res_t              res;

  // Consume the held byte unless it is a last byte with nowhere to go
  assign consume     = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (consume) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  assign beat.valid = consume;
  assign beat.data  = s1_data_r;
  assign beat.last  = s1_last_r;

  davpf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  davpf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat_i      (beat),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  davpf_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (res_valid),
    .res_i  (res),
    .free_o (out_free),
    .out_ch (out_ch)
  );

  // A stalled last byte stays in the input register
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && !out_free |=> s1_valid_r && s1_last_r)
    else $error("last byte lost while output stalled");

endmodule

`default_nettype wire
